### sv/assert_macros.svh
// Assertion macros shared by the decimator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// House form: block clock clk, asynchronous reset arst_n.
`define ASSERT_DEF(label, prop, msg) \
	`ASSERT_CLK_RST(label, clk, arst_n, prop, msg)

`endif

### sv/rdpd_pkg.sv
// Types, constants and helper functions for the radial distance point decimator.
// No dependencies; imported by the interfaces and all modules.
package rdpd_pkg;

	localparam int unsigned CoordW  = 32;
	localparam int unsigned SqW     = 2 * CoordW;
	localparam int unsigned SumW    = SqW + 2;
	localparam int unsigned ThrW    = 31;
	localparam int unsigned Thr2W   = 2 * ThrW;
	localparam int unsigned NumHeld = 3;
	localparam int unsigned AddrW   = 3;
	localparam int unsigned DataW   = 32;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_POINTS  = 2'd0;
	localparam kind_t KIND_LINE    = 2'd1;
	localparam kind_t KIND_POLYGON = 2'd2;

	typedef logic [1:0] count_t;
	localparam count_t MIN_POLYGON = 2'd3;
	localparam count_t MIN_LINE    = 2'd2;
	localparam count_t MIN_OTHER   = 2'd1;

	// Register word index, taken from paddr[2]
	localparam logic REG_DISTANCE_THRESHOLD = 1'b0;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
	} point_t;

	typedef struct packed {
		point_t pt;
		logic   done;
	} result_t;

	typedef logic [2:0][SqW-1:0] sq3_t;

	// One burst of results handed to the output buffer
	typedef struct packed {
		logic                      load;
		count_t                    cnt;
		result_t [NumHeld-1:0]     ent;
	} batch_t;

	function automatic count_t min_count(kind_t kind);
		count_t m;
		unique case (kind)
			KIND_POLYGON: m = MIN_POLYGON;
			KIND_LINE:    m = MIN_LINE;
			default:      m = MIN_OTHER;
		endcase
		return m;
	endfunction

	// |a - b| of two signed coordinates; always fits in CoordW unsigned bits
	function automatic logic [CoordW-1:0] abs_diff(logic signed [CoordW-1:0] a,
		logic signed [CoordW-1:0] b);
		logic [CoordW:0] d;
		logic [CoordW:0] nd;
		d  = {a[CoordW-1], a} - {b[CoordW-1], b};
		nd = -d;
		return d[CoordW] ? nd[CoordW-1:0] : d[CoordW-1:0];
	endfunction

endpackage

### sv/rdpd_point_if.sv
// Input channel of the decimator: one point per transfer, valid/ready handshake.
// Depends on rdpd_pkg for the coordinate width.
interface rdpd_point_if import rdpd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] point_x;
	logic signed [CoordW-1:0] point_y;
	logic signed [CoordW-1:0] point_z;
	kind_t                    shape_kind;
	logic                     end_of_part;

	modport source (output valid, point_x, point_y, point_z, shape_kind, end_of_part,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, shape_kind, end_of_part,
		output ready);
endinterface

### sv/rdpd_kept_if.sv
// Output channel of the decimator: one kept point per transfer, valid/ready handshake.
// Depends on rdpd_pkg for the coordinate width.
interface rdpd_kept_if import rdpd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] kept_x;
	logic signed [CoordW-1:0] kept_y;
	logic signed [CoordW-1:0] kept_z;
	logic                     part_done;

	modport source (output valid, kept_x, kept_y, kept_z, part_done, input ready);
	modport sink (input valid, kept_x, kept_y, kept_z, part_done, output ready);
endinterface

### sv/rdpd_sqdist.sv
// Per-axis squared distance between two points (three 32x32 unsigned squares).
// Depends on rdpd_pkg.
module rdpd_sqdist import rdpd_pkg::*; (
	input  point_t a,
	input  point_t b,
	output sq3_t   sq
);

	logic [CoordW-1:0] dx;
	logic [CoordW-1:0] dy;
	logic [CoordW-1:0] dz;

	assign dx = abs_diff(a.x, b.x);
	assign dy = abs_diff(a.y, b.y);
	assign dz = abs_diff(a.z, b.z);

	assign sq[0] = SqW'(dx) * SqW'(dx);
	assign sq[1] = SqW'(dy) * SqW'(dy);
	assign sq[2] = SqW'(dz) * SqW'(dz);

endmodule

### sv/rdpd_outbuf.sv
// Result buffer: holds one burst of up to three kept points and drains it in order.
// Depends on rdpd_pkg and rdpd_kept_if.
module rdpd_outbuf import rdpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  batch_t            batch,
	output logic              free,
	rdpd_kept_if.source       kept
);

	result_t [NumHeld-1:0] ent_q;
	count_t                rem_q;
	logic                  xfer;

	assign kept.valid     = (rem_q != '0);
	assign kept.kept_x    = ent_q[0].pt.x;
	assign kept.kept_y    = ent_q[0].pt.y;
	assign kept.kept_z    = ent_q[0].pt.z;
	assign kept.part_done = ent_q[0].done;

	assign xfer = kept.valid && kept.ready;
	// a new burst may load when the buffer is empty or empties at this edge
	assign free = (rem_q == '0) || (rem_q == 2'd1 && kept.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (batch.load) begin
			rem_q <= batch.cnt;
		end else if (xfer) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (batch.load) begin
			ent_q <= batch.ent;
		end else if (xfer) begin
			for (int i = 0; i < NumHeld - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule

### sv/radial_distance_point_decimator.sv
// Radial distance point decimator: keeps points of a part spaced beyond a threshold.
// Uses rdpd_pkg, rdpd_point_if, rdpd_kept_if, rdpd_sqdist, rdpd_outbuf, assert_macros.svh.
//
// Points of a part enter on the points channel one per transfer, with end_of_part on
// the last one. Kept points leave on the kept channel, part_done on the last kept point
// of an emitted part; parts that keep fewer points than their shape needs (3 polygon,
// 2 line, 1 otherwise) give no output. The threshold is written over the APB port at
// byte address 0 (31 bits) and takes effect once its square in t2_q is registered.
// The first result of an item passes the stage one and stage two registers and the
// result buffer before it is offered on the kept channel.
// Throughput: one point per cycle while the result buffer is free. Stage one squares
// the axis distances to both the stored anchor and the point ahead; stage two picks
// the right set, compares against the squared threshold and updates the held points.
// A burst of results leaves one per transfer, and the input waits while it drains.
// When the receiver stalls, the result buffer holds its burst, stage two waits, and
// the stall reaches points.ready through the two stages.
// Reset clears the threshold, the pipeline and the result buffer; the next point
// starts a new part.
`include "assert_macros.svh"

module radial_distance_point_decimator import rdpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rdpd_point_if.sink        points,
	rdpd_kept_if.source       kept,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	// configuration
	logic [ThrW-1:0]  thr_q;
	logic [Thr2W-1:0] t2_q;
	logic             reg_wr;

	// stage one
	logic   v_s1_q;
	point_t p_s1;
	kind_t  kind_s1;
	logic   last_s1;

	// stage two
	logic   v_s2_q;
	point_t p_s2;
	kind_t  kind_s2;
	logic   last_s2;
	sq3_t   sqa_s2;
	sq3_t   sqb_s2;
	logic   b_ok_s2;

	// part state
	point_t                anchor_q;
	point_t [NumHeld-1:0]  held_q;
	logic                  in_part_q;
	count_t                kc_q;

	// handshake
	logic   in_xfer;
	logic   s1_adv;
	logic   r_ready;
	logic   r_fire;
	logic   buf_free;

	// stage two datapath
	sq3_t                  sqa_c;
	sq3_t                  sqb_c;
	sq3_t                  sq_sel;
	logic [SumW-1:0]       dist_sum;
	logic                  far;
	count_t                minc;
	logic                  first;
	count_t                kc_eff;
	logic                  keep;
	count_t                held_idx;
	count_t                kc_new;
	logic                  reach;
	count_t                held_n;
	point_t [NumHeld-1:0]  hp;
	point_t [NumHeld-1:0]  held_d;
	batch_t                batch;

	// APB register access
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == REG_DISTANCE_THRESHOLD);
	assign prdata = (paddr[2] == REG_DISTANCE_THRESHOLD) ?
		DataW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			t2_q  <= '0;
		end else begin
			if (reg_wr) begin
				thr_q <= pwdata[ThrW-1:0];
			end
			t2_q <= Thr2W'(thr_q) * Thr2W'(thr_q);
		end
	end

	// pipeline control
	assign r_fire        = v_s2_q && buf_free;
	assign r_ready       = !v_s2_q || r_fire;
	assign s1_adv        = v_s1_q && r_ready;
	assign points.ready  = !v_s1_q || r_ready;
	assign in_xfer       = points.valid && points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				v_s1_q <= 1'b1;
			end else if (s1_adv) begin
				v_s1_q <= 1'b0;
			end
			if (s1_adv) begin
				v_s2_q <= 1'b1;
			end else if (r_fire) begin
				v_s2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			p_s1.x  <= points.point_x;
			p_s1.y  <= points.point_y;
			p_s1.z  <= points.point_z;
			kind_s1 <= points.shape_kind;
			last_s1 <= points.end_of_part;
		end
	end

	// Square distances to the anchor as it stands and to the point now leaving
	// stage two; the latter becomes the anchor if that point is kept.
	rdpd_sqdist u_sq_anchor (
		.a  (p_s1),
		.b  (anchor_q),
		.sq (sqa_c)
	);

	rdpd_sqdist u_sq_ahead (
		.a  (p_s1),
		.b  (p_s2),
		.sq (sqb_c)
	);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			p_s2    <= p_s1;
			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			sqa_s2  <= sqa_c;
			sqb_s2  <= sqb_c;
			b_ok_s2 <= v_s2_q && keep && !last_s2;
		end
	end

	// keep decision and held point bookkeeping
	always_comb begin
		sq_sel   = b_ok_s2 ? sqb_s2 : sqa_s2;
		dist_sum = SumW'(sq_sel[0]) + SumW'(sq_sel[1]) + SumW'(sq_sel[2]);
		far      = dist_sum > SumW'(t2_q);
		minc     = min_count(kind_s2);
		first    = !in_part_q;
		kc_eff   = first ? '0 : kc_q;
		keep     = first || far;
		held_idx = (kc_eff >= minc) ? count_t'(1) : kc_eff;
		kc_new   = (keep && kc_eff != 2'd3) ? kc_eff + 2'd1 : kc_eff;
		reach    = kc_new >= minc;
		held_n   = held_idx + count_t'(keep);

		hp = held_q;
		for (int i = 0; i < NumHeld; i++) begin
			if (keep && count_t'(i) == held_idx) begin
				hp[i] = p_s2;
			end
		end

		// move the newest kept point to the front once the others are sent
		held_d = hp;
		if (!last_s2 && keep && reach && held_n > 2'd1) begin
			for (int i = 0; i < NumHeld; i++) begin
				if (count_t'(i) + 2'd1 == held_n) begin
					held_d[0] = hp[i];
				end
			end
		end

		batch.load = r_fire;
		for (int i = 0; i < NumHeld; i++) begin
			batch.ent[i].pt   = hp[i];
			batch.ent[i].done = last_s2 && (count_t'(i) + 2'd1 == held_n);
		end
		if (last_s2) begin
			batch.cnt = reach ? held_n : '0;
		end else begin
			batch.cnt = (keep && reach) ? held_n - 2'd1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_part_q <= 1'b0;
			kc_q      <= '0;
			anchor_q  <= '0;
		end else if (r_fire) begin
			in_part_q <= !last_s2;
			kc_q      <= last_s2 ? '0 : kc_new;
			if (keep) begin
				anchor_q <= p_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (r_fire) begin
			held_q <= held_d;
		end
	end

	rdpd_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.batch  (batch),
		.free   (buf_free),
		.kept   (kept)
	);

	`ASSERT_DEF(a_idle_count_clear, !in_part_q |-> kc_q == '0, "kept count set outside a part")
	`ASSERT_DEF(a_ahead_in_part, v_s2_q && b_ok_s2 |-> in_part_q, "anchor forward without open part")
	`ASSERT_DEF(a_done_ends_burst, kept.valid && kept.ready && kept.part_done |=> !kept.valid || $past(r_fire), "results follow part_done in same burst")

endmodule
